/* hw/rtl/byte_ring_buffer_macros.svh */
// assertion macros for the byte ring buffer controller
`ifndef BYTE_RING_BUFFER_MACROS_SVH
`define BYTE_RING_BUFFER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never be true out of reset
`define BRB_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

/* hw/rtl/brb_pkg.sv */
// types, codes and size helpers for the byte ring buffer
package brb_pkg;

  // buffer geometry
  localparam int BUF_BYTES = 1024;
  localparam int MAX_XFER  = 64;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int CNT_W     = ADDR_W + 1;

  // field widths
  localparam int OP_W     = 3;
  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 10;
  localparam int FREE_W   = 10;
  localparam int CONTIG_W = 11;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
  localparam logic [OP_W-1:0] OP_READ    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_W-1:0] OP_ADVANCE = 3'd3;
  localparam logic [OP_W-1:0] OP_DISCARD = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_LEN = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_ROOM = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_BUSY    = 2'd3;

  typedef logic [ADDR_W-1:0] pos_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // memory port request from the controller
  typedef struct packed {
    logic              we;
    pos_t              waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    pos_t              raddr;
  } mem_req_t;

  // result load request toward the output register
  typedef struct packed {
    logic                load;
    logic [STATUS_W-1:0] status;
    logic                from_mem;
    logic                last;
    logic [USED_W-1:0]   used;
    logic [FREE_W-1:0]   free;
    logic [CONTIG_W-1:0] contig;
  } res_t;

  // bytes held between read and write positions
  function automatic cnt_t used_cnt(pos_t rp, pos_t wp);
    if (wp >= rp) return CNT_W'(wp) - CNT_W'(rp);
    return CNT_W'(BUF_BYTES) - CNT_W'(rp) + CNT_W'(wp);
  endfunction

  // writable bytes, one slot always left empty
  function automatic cnt_t free_cnt(pos_t rp, pos_t wp);
    return CNT_W'(BUF_BYTES - 1) - used_cnt(rp, wp);
  endfunction

  // free bytes from the write position up to wrap or read position
  function automatic cnt_t contig_cnt(pos_t rp, pos_t wp);
    if (wp >= rp) return CNT_W'(BUF_BYTES) - CNT_W'(wp);
    return CNT_W'(rp) - CNT_W'(wp) - CNT_W'(1);
  endfunction

  // position plus offset, modulo buffer size (offset below buffer size)
  function automatic pos_t wrap_add(pos_t pos, cnt_t n);
    cnt_t s;
    s = CNT_W'(pos) + n;
    if (s >= CNT_W'(BUF_BYTES)) s = s - CNT_W'(BUF_BYTES);
    return ADDR_W'(s);
  endfunction

  // position minus offset, modulo buffer size (offset below buffer size)
  function automatic pos_t wrap_sub(pos_t pos, cnt_t n);
    if (CNT_W'(pos) >= n) return ADDR_W'(CNT_W'(pos) - n);
    return ADDR_W'(CNT_W'(pos) + CNT_W'(BUF_BYTES) - n);
  endfunction

  // length check against the transfer cap and a size limit
  function automatic logic [STATUS_W-1:0] check_len(logic [LEN_W-1:0] len, cnt_t limit);
    if (len == '0 || 32'(len) > 32'(MAX_XFER)) return STAT_BAD_LEN;
    if (32'(len) > 32'(limit)) return STAT_NO_ROOM;
    return STAT_OK;
  endfunction

endpackage

/* hw/rtl/byte_ring_buffer.sv */
// Circular byte buffer of 1024 bytes (1023 usable) held in a single-port-write,
// registered-read ram. After reset a clearing pass zeroes the store, one byte a
// cycle, so no item is accepted until the whole store is clear. Write beats,
// advance, discard and rejected requests each give one result, so a write of n
// bytes streams in at one beat per cycle while the output is not stalled. A read
// or peek of n bytes gives n results, one per cycle while the output is not
// stalled; each byte is read from the ram in the read state, held in the ram's
// read register and then loaded into the output register, so these results come
// later than other results. The next item is taken once the last byte has left
// the ram, and only when the output register is empty or its result transfers.
module byte_ring_buffer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [brb_pkg::OP_W-1:0]        in_op,
  input  logic [brb_pkg::LEN_W-1:0]       in_length,
  input  logic [brb_pkg::BYTE_W-1:0]      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [brb_pkg::STATUS_W-1:0]    out_status,
  output logic [brb_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_last,
  output logic [brb_pkg::USED_W-1:0]      out_used_bytes,
  output logic [brb_pkg::FREE_W-1:0]      out_free_bytes,
  output logic [brb_pkg::CONTIG_W-1:0]    out_contiguous_free
);

  import brb_pkg::*;

  mem_req_t          mem_req;
  res_t              res;
  logic [BYTE_W-1:0] ram_rdata;
  logic              out_free;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [BYTE_W-1:0]   byte_r;
  logic                last_r;
  logic [USED_W-1:0]   used_r;
  logic [FREE_W-1:0]   free_r;
  logic [CONTIG_W-1:0] contig_r;

  brb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_length    (in_length),
    .in_data_byte (in_data_byte),
    .out_free     (out_free),
    .mem_req      (mem_req),
    .res          (res)
  );

  brb_ram #(
    .DEPTH (BUF_BYTES),
    .WIDTH (BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (ram_rdata)
  );

  // output register is free when empty or its result transfers this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res.load) begin
      status_r <= res.status;
      byte_r   <= res.from_mem ? ram_rdata : '0;
      last_r   <= res.last;
      used_r   <= res.used;
      free_r   <= res.free;
      contig_r <= res.contig;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_byte            = byte_r;
  assign out_last            = last_r;
  assign out_used_bytes      = used_r;
  assign out_free_bytes      = free_r;
  assign out_contiguous_free = contig_r;

endmodule

/* hw/rtl/brb_ram.sv */
// simple dual port ram, one write and one registered read port
module brb_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/brb_ctrl.sv */
// controller: position bookkeeping, length checks, clearing pass, read sequencer
`include "byte_ring_buffer_macros.svh"

module brb_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [brb_pkg::OP_W-1:0]      in_op,
  input  logic [brb_pkg::LEN_W-1:0]     in_length,
  input  logic [brb_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          out_free,
  output brb_pkg::mem_req_t             mem_req,
  output brb_pkg::res_t                 res
);

  import brb_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  pos_t             clr_addr_r, clr_addr_nxt;
  pos_t             rd_pos_r, rd_pos_nxt;
  pos_t             wr_pos_r, wr_pos_nxt;
  logic [LEN_W-1:0] beats_r, beats_nxt;
  logic             drop_r, drop_nxt;
  pos_t             rd_addr_r, rd_addr_nxt;
  logic [LEN_W-1:0] rd_left_r, rd_left_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_last_r, pend_last_nxt;

  logic                in_xfer;
  logic [STATUS_W-1:0] st;
  cnt_t                used_now;
  cnt_t                free_now;

  // new items only when idle, no byte in flight and the output can take a result
  assign in_stall = !(state_r == ST_IDLE && !pend_r && out_free);
  assign in_xfer  = in_valid && !in_stall;

  assign used_now = used_cnt(rd_pos_r, wr_pos_r);
  assign free_now = free_cnt(rd_pos_r, wr_pos_r);

  // next state and memory / result requests
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    rd_pos_nxt    = rd_pos_r;
    wr_pos_nxt    = wr_pos_r;
    beats_nxt     = beats_r;
    drop_nxt      = drop_r;
    rd_addr_nxt   = rd_addr_r;
    rd_left_nxt   = rd_left_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    mem_req       = '0;
    res.load      = 1'b0;
    res.status    = STAT_OK;
    res.from_mem  = 1'b0;
    res.last      = 1'b1;
    st            = STAT_OK;

    // byte back from memory moves to the output register
    if (pend_r && out_free) begin
      res.load     = 1'b1;
      res.from_mem = 1'b1;
      res.last     = pend_last_r;
      pend_nxt     = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        // zero one entry per cycle after reset
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr_r;
        mem_req.wdata = '0;
        clr_addr_nxt  = ADDR_W'(CNT_W'(clr_addr_r) + CNT_W'(1));
        if (clr_addr_r == ADDR_W'(BUF_BYTES - 1)) state_nxt = ST_IDLE;
      end

      ST_READ: begin
        // issue one read per cycle while the previous byte can move on
        if (rd_left_r != '0 && (!pend_r || out_free)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_addr_r;
          rd_addr_nxt   = wrap_add(rd_addr_r, CNT_W'(1));
          rd_left_nxt   = rd_left_r - LEN_W'(1);
          pend_nxt      = 1'b1;
          pend_last_nxt = (rd_left_r == LEN_W'(1));
          if (rd_left_r == LEN_W'(1)) state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          res.load = 1'b1;
          if (in_op == OP_WRITE) begin
            if (beats_r == '0) begin
              // first beat: check and reserve the whole transfer
              st = check_len(in_length, free_now);
              res.status = st;
              if (st != STAT_OK) begin
                if (in_length > LEN_W'(1)) begin
                  beats_nxt = in_length - LEN_W'(1);
                  drop_nxt  = 1'b1;
                end
              end else begin
                wr_pos_nxt    = wrap_add(wr_pos_r, CNT_W'(in_length));
                mem_req.we    = 1'b1;
                mem_req.waddr = wr_pos_r;
                mem_req.wdata = in_data_byte;
                beats_nxt     = in_length - LEN_W'(1);
                drop_nxt      = 1'b0;
              end
            end else begin
              // later beat: fill the next reserved slot unless dropping
              if (!drop_r) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wrap_sub(wr_pos_r, CNT_W'(beats_r));
                mem_req.wdata = in_data_byte;
              end
              beats_nxt = beats_r - LEN_W'(1);
              if (beats_r == LEN_W'(1)) drop_nxt = 1'b0;
            end
          end else if (beats_r != '0) begin
            res.status = STAT_BUSY;
          end else begin
            case (in_op)
              OP_READ, OP_PEEK: begin
                st = check_len(in_length, used_now);
                if (st != STAT_OK) begin
                  res.status = st;
                end else begin
                  // results come from the read sequencer
                  res.load = 1'b0;
                  if (in_op == OP_READ) rd_pos_nxt = wrap_add(rd_pos_r, CNT_W'(in_length));
                  rd_addr_nxt = rd_pos_r;
                  rd_left_nxt = in_length;
                  state_nxt   = ST_READ;
                end
              end
              OP_ADVANCE: begin
                st = check_len(in_length, free_now);
                res.status = st;
                if (st == STAT_OK) wr_pos_nxt = wrap_add(wr_pos_r, CNT_W'(in_length));
              end
              OP_DISCARD: begin
                st = check_len(in_length, used_now);
                res.status = st;
                if (st == STAT_OK) rd_pos_nxt = wrap_add(rd_pos_r, CNT_W'(in_length));
              end
              default: res.status = STAT_BAD_LEN;
            endcase
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // sizes after the step
    res.used   = USED_W'(used_cnt(rd_pos_nxt, wr_pos_nxt));
    res.free   = FREE_W'(free_cnt(rd_pos_nxt, wr_pos_nxt));
    res.contig = CONTIG_W'(contig_cnt(rd_pos_nxt, wr_pos_nxt));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      rd_pos_r   <= '0;
      wr_pos_r   <= '0;
      beats_r    <= '0;
      drop_r     <= 1'b0;
      rd_left_r  <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      rd_pos_r   <= rd_pos_nxt;
      wr_pos_r   <= wr_pos_nxt;
      beats_r    <= beats_nxt;
      drop_r     <= drop_nxt;
      rd_left_r  <= rd_left_nxt;
      pend_r     <= pend_nxt;
    end
  end

  // sequencer payload
  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    pend_last_r <= pend_last_nxt;
  end

  // checks
  `BRB_ASSERT_NEVER(a_no_rw_overlap, mem_req.we && mem_req.re,
                    "memory read and write issued in the same cycle")
  `BRB_ASSERT(a_drop_needs_beats, drop_r |-> beats_r != '0,
              "dropping a write with no beats pending")
  `BRB_ASSERT(a_stream_has_work, state_r == ST_READ |-> rd_left_r != '0,
              "read stream active with nothing left to issue")
  `BRB_ASSERT(a_beats_only_idle, beats_r != '0 |-> state_r == ST_IDLE,
              "read stream started while write beats pending")
  `BRB_ASSERT_NEVER(a_clear_quiet, state_r == ST_CLEAR && res.load,
                    "result produced during clearing pass")

endmodule

/* dv/byte_ring_buffer_tb.sv */
// self-checking testbench for the byte ring buffer: directed and random traffic
`timescale 1ns / 1ps

module byte_ring_buffer_tb;
  import brb_pkg::*;

  localparam int ITEM_GOAL  = 400;
  localparam int CALM_ITEMS = 60;
  localparam int QUIET_MAX  = 3000;
  localparam int PRINT_CAP  = 40;

  // op codes the block does not define
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [USED_W-1:0]   used;
    logic [FREE_W-1:0]   free;
    logic [CONTIG_W-1:0] contig;
  } ring_result_t;

  // mirror of the ring contents and positions, plus the results still owed
  class ring_mirror;
    logic [BYTE_W-1:0] mirror_mem [BUF_BYTES];
    int                rd_pos;
    int                wr_pos;
    int                beats_due;
    bit                dropping;
    ring_result_t      pending_results[$];
    int                mismatches;

    function new();
      foreach (mirror_mem[i]) mirror_mem[i] = '0;
      rd_pos     = 0;
      wr_pos     = 0;
      beats_due  = 0;
      dropping   = 1'b0;
      mismatches = 0;
    endfunction

    function int used_count();
      if (wr_pos >= rd_pos) return wr_pos - rd_pos;
      return BUF_BYTES - rd_pos + wr_pos;
    endfunction

    function int free_count();
      return BUF_BYTES - used_count() - 1;
    endfunction

    function int contig_count();
      if (wr_pos >= rd_pos) return BUF_BYTES - wr_pos;
      return rd_pos - wr_pos - 1;
    endfunction

    // length against the transfer cap, then against the room or data on hand
    function logic [STATUS_W-1:0] size_verdict(int n, int limit);
      if (n == 0 || n > MAX_XFER) return STAT_BAD_LEN;
      if (n > limit) return STAT_NO_ROOM;
      return STAT_OK;
    endfunction

    // sizes are taken after the whole step
    function void expect_result(logic [STATUS_W-1:0] status, logic [BYTE_W-1:0] data,
                                logic last);
      ring_result_t r;
      r.status = status;
      r.data   = data;
      r.last   = last;
      r.used   = USED_W'(used_count());
      r.free   = FREE_W'(free_count());
      r.contig = CONTIG_W'(contig_count());
      pending_results.push_back(r);
    endfunction

    // step the mirror for one accepted input transfer
    function void note_transfer(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                                logic [BYTE_W-1:0] data);
      logic [STATUS_W-1:0] verdict;
      int n;
      int start;
      int i;
      n = int'(len);
      if (op == OP_WRITE) begin
        // first beat checks and reserves the whole write
        if (beats_due == 0) begin
          verdict = size_verdict(n, free_count());
          if (verdict != STAT_OK) begin
            if (n > 1) begin
              beats_due = n - 1;
              dropping  = 1'b1;
            end
            expect_result(verdict, '0, 1'b1);
            return;
          end
          wr_pos    = (wr_pos + n) % BUF_BYTES;
          beats_due = n;
          dropping  = 1'b0;
        end
        if (!dropping) mirror_mem[(wr_pos + BUF_BYTES - beats_due) % BUF_BYTES] = data;
        beats_due--;
        if (beats_due == 0) dropping = 1'b0;
        expect_result(STAT_OK, '0, 1'b1);
      end else if (beats_due != 0) begin
        expect_result(STAT_BUSY, '0, 1'b1);
      end else if (op == OP_READ || op == OP_PEEK) begin
        verdict = size_verdict(n, used_count());
        if (verdict != STAT_OK) begin
          expect_result(verdict, '0, 1'b1);
        end else begin
          start = rd_pos;
          if (op == OP_READ) rd_pos = (rd_pos + n) % BUF_BYTES;
          for (i = 0; i < n; i++)
            expect_result(STAT_OK, mirror_mem[(start + i) % BUF_BYTES], i == n - 1);
        end
      end else if (op == OP_ADVANCE) begin
        verdict = size_verdict(n, free_count());
        if (verdict == STAT_OK) wr_pos = (wr_pos + n) % BUF_BYTES;
        expect_result(verdict, '0, 1'b1);
      end else if (op == OP_DISCARD) begin
        verdict = size_verdict(n, used_count());
        if (verdict == STAT_OK) rd_pos = (rd_pos + n) % BUF_BYTES;
        expect_result(verdict, '0, 1'b1);
      end else begin
        expect_result(STAT_BAD_LEN, '0, 1'b1);
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // compare one output transfer with the oldest owed result
    task check_result(ring_result_t got);
      ring_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: status %0d byte %02h",
                                  got.status, got.data));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.data !== want.data || got.last !== want.last ||
          got.used !== want.used || got.free !== want.free || got.contig !== want.contig)
        report_mismatch($sformatf(
          "got st %0d byte %02h last %0d used %0d free %0d contig %0d, want %0d %02h %0d %0d %0d %0d",
          got.status, got.data, got.last, got.used, got.free, got.contig,
          want.status, want.data, want.last, want.used, want.free, want.contig));
    endtask
  endclass

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_op        = '0;
  logic [LEN_W-1:0]    in_length    = '0;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last;
  logic [USED_W-1:0]   out_used_bytes;
  logic [FREE_W-1:0]   out_free_bytes;
  logic [CONTIG_W-1:0] out_contiguous_free;

  ring_mirror mirror = new();
  int         sent   = 0;
  bit         calm   = 1'b0;

  byte_ring_buffer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_length           (in_length),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_byte            (out_byte),
    .out_last            (out_last),
    .out_used_bytes      (out_used_bytes),
    .out_free_bytes      (out_free_bytes),
    .out_contiguous_free (out_contiguous_free)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // check every output transfer
  always @(posedge clk) begin : result_monitor
    ring_result_t seen;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen.status = out_status;
      seen.data   = out_byte;
      seen.last   = out_last;
      seen.used   = out_used_bytes;
      seen.free   = out_free_bytes;
      seen.contig = out_contiguous_free;
      mirror.check_result(seen);
    end
  end

  // receiver stall bursts, none in the calm tail
  initial begin : sink_stall
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  // give up after a long stretch with no transfer on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // present one item, hold it until the transfer, then maybe idle
  task automatic push_item(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                           input logic [BYTE_W-1:0] data);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_length    <= len;
    in_data_byte <= data;
    do @(posedge clk); while (in_stall !== 1'b0);
    mirror.note_transfer(op, len, data);
    sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // write beats until the open write is done, with an optional busy poke
  task automatic stream_write(input int n, input bit poke);
    push_item(OP_WRITE, LEN_W'(n), BYTE_W'($urandom));
    while (mirror.beats_due != 0) begin
      if (poke && $urandom_range(0, 3) == 0)
        push_item(OP_W'($urandom_range(1, 7)), LEN_W'($urandom_range(0, 127)),
                  BYTE_W'($urandom));
      push_item(OP_WRITE, LEN_W'($urandom_range(0, 127)), BYTE_W'($urandom));
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk);
  endtask

  // edge cases from reset: bad lengths, empty reads, busy, unknown ops
  task automatic directed_items();
    push_item(OP_READ, 7'd1, 8'h00);
    push_item(OP_WRITE, 7'd0, 8'h11);
    push_item(OP_DISCARD, 7'd65, 8'h00);
    push_item(OP_PEEK, 7'd127, 8'hFF);
    push_item(OP_ADVANCE, 7'd0, 8'h00);
    push_item(OP_DISCARD, 7'd1, 8'h00);
    push_item(OP_WRITE, 7'd3, 8'h00);
    push_item(OP_WRITE, 7'd0, 8'hFF);
    push_item(OP_WRITE, 7'd127, 8'hA5);
    push_item(OP_PEEK, 7'd3, 8'h00);
    push_item(OP_WRITE, 7'd2, 8'h5A);
    push_item(OP_READ, 7'd1, 8'h00);
    push_item(OP_UNUSED_LO, 7'd1, 8'h00);
    push_item(OP_WRITE, 7'd64, 8'hC3);
    push_item(OP_UNUSED_LO, 7'd4, 8'h00);
    push_item(OP_UNUSED_HI, 7'd64, 8'hFF);
    push_item(OP_READ, 7'd5, 8'h00);
    push_item(OP_ADVANCE, 7'd64, 8'h00);
    push_item(OP_DISCARD, 7'd64, 8'h00);
    push_item(OP_READ, 7'd64, 8'h00);
  endtask

  // one random round: mostly well-formed sequences, some noise
  task automatic random_round();
    int pick;
    int used_now;
    int free_now;
    int n;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 82) begin
      while (mirror.beats_due != 0)
        push_item(OP_WRITE, LEN_W'($urandom_range(0, 127)), BYTE_W'($urandom));
    end
    used_now = mirror.used_count();
    free_now = mirror.free_count();
    if (pick < 35) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
      stream_write(n, $urandom_range(0, 9) == 0);
    end else if (pick < 55) begin
      if (used_now == 0 || $urandom_range(0, 9) == 0)
        n = $urandom_range(1, 8) + used_now;
      else if ($urandom_range(0, 5) == 0)
        n = $urandom_range(1, used_now < MAX_XFER ? used_now : MAX_XFER);
      else
        n = $urandom_range(1, used_now < 12 ? used_now : 12);
      if (n > MAX_XFER) n = MAX_XFER;
      push_item($urandom_range(0, 1) ? OP_READ : OP_PEEK, LEN_W'(n), BYTE_W'($urandom));
    end else if (pick < 66) begin
      n = free_now < MAX_XFER ? free_now : MAX_XFER;
      push_item(OP_ADVANCE, LEN_W'($urandom_range(0, n < 1 ? 1 : n)), BYTE_W'($urandom));
    end else if (pick < 79) begin
      n = used_now < MAX_XFER ? used_now : MAX_XFER;
      push_item(OP_DISCARD, LEN_W'($urandom_range(0, n < 1 ? 1 : n)), BYTE_W'($urandom));
    end else if (pick < 82) begin
      // fill to the brim, bounce a write off the full ring, then drain some
      while (mirror.free_count() > 0) begin
        n = mirror.free_count();
        push_item(OP_ADVANCE, LEN_W'(n < MAX_XFER ? n : MAX_XFER), BYTE_W'($urandom));
      end
      stream_write($urandom_range(1, 4), 1'b0);
      push_item(OP_ADVANCE, 7'd1, BYTE_W'($urandom));
      push_item(OP_PEEK, LEN_W'($urandom_range(1, MAX_XFER)), BYTE_W'($urandom));
      repeat ($urandom_range(2, 15)) push_item(OP_DISCARD, 7'd64, BYTE_W'($urandom));
    end else begin
      // noise, may leave a write open so that the next ops hit busy
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(0, 7);
        if (k == int'(OP_WRITE) && $urandom_range(0, 4) != 0) n = $urandom_range(0, 6);
        else n = $urandom_range(0, 127);
        push_item(OP_W'(k), LEN_W'(n), BYTE_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    hold_until_drained();
    while (sent < ITEM_GOAL) begin
      if (sent >= ITEM_GOAL - CALM_ITEMS) calm = 1'b1;
      random_round();
    end
    while (mirror.beats_due != 0)
      push_item(OP_WRITE, LEN_W'($urandom_range(0, 127)), BYTE_W'($urandom));
    in_valid <= 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mirror.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/brb_pkg.sv
hw/rtl/brb_ram.sv
hw/rtl/brb_ctrl.sv
hw/rtl/byte_ring_buffer.sv
dv/byte_ring_buffer_tb.sv
